>>> rtl/ksa_pkg.sv
// ----------------------------------------------------------------------------
// ksa_pkg
// Shared types and codes for the key slot allocator.
// ----------------------------------------------------------------------------
package ksa_pkg;

    localparam int SLOT_W = 6;
    localparam int WORD_W = 64;
    localparam int KEY_W  = 4 * WORD_W;

    // operation codes
    localparam logic [1:0] FUNC_REGISTER   = 2'd0;
    localparam logic [1:0] FUNC_UNREGISTER = 2'd1;
    localparam logic [1:0] FUNC_GET        = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot_index;
        logic [WORD_W-1:0] key_word_0;
        logic [WORD_W-1:0] key_word_1;
        logic [WORD_W-1:0] key_word_2;
        logic [WORD_W-1:0] key_word_3;
    } ksa_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_slot;
        logic [WORD_W-1:0] out_word_0;
        logic [WORD_W-1:0] out_word_1;
        logic [WORD_W-1:0] out_word_2;
        logic [WORD_W-1:0] out_word_3;
    } ksa_out_t;

    // result of the lowest-free-slot search
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } free_slot_t;

endpackage

>>> rtl/ksa_ram.sv
// ----------------------------------------------------------------------------
// ksa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ksa_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ksa_free_enc.sv
// ----------------------------------------------------------------------------
// ksa_free_enc
// Finds the lowest free slot in the used mask, two-level priority encode.
// ----------------------------------------------------------------------------
module ksa_free_enc #(
    parameter int NUM_SLOTS = 63
) (
    input  logic [NUM_SLOTS-1:0] used_mask,
    output ksa_pkg::free_slot_t  result
);
    import ksa_pkg::*;

    localparam int GRP   = 8;
    localparam int NGRP  = (NUM_SLOTS + GRP - 1) / GRP;
    localparam int PAD_W = NGRP * GRP;

    logic [NUM_SLOTS-1:0] free_bits;
    logic [PAD_W-1:0]     free_pad;
    logic [NGRP-1:0]      grp_found;
    logic [2:0]           grp_low [NGRP];
    logic [2:0]           sel_grp;
    logic                 any_free;

    // invert at the mask width so the padding bits above the last slot stay busy
    assign free_bits = ~used_mask;
    assign free_pad  = PAD_W'(free_bits);

    // lowest free bit inside each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_found[g] = |free_pad[g*GRP +: GRP];
            grp_low[g]   = 3'd0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (free_pad[g*GRP + b])
                begin
                    grp_low[g] = 3'(b);
                end
            end
        end
    end

    // lowest group that has a free bit
    always_comb
    begin
        sel_grp  = 3'd0;
        any_free = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_found[g])
            begin
                sel_grp  = 3'(g);
                any_free = 1'b1;
            end
        end
    end

    assign result.found = any_free;
    assign result.slot  = any_free ? {sel_grp, grp_low[sel_grp]} : '0;

endmodule

>>> rtl/key_slot_allocator.sv
// ----------------------------------------------------------------------------
// key_slot_allocator
// Bitmap slot allocator holding one 256-bit key per slot.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready/in_data carry one request transaction: func selects
//   register (claim lowest free slot, store key), unregister (free a slot)
//   or get (read back the key of a used slot).
//   out_valid/out_ready/out_data carry exactly one response per request,
//   in request order, with status ok, full or miss.
//   the accept edge loads the input register; the response registers and
//   the key RAM registered read are loaded from it through the mask logic
//   when the request advances. throughput is one transaction per cycle
//   while out_ready stays high, set by the registered mask update and the one
//   write / one read port of the RAM.
//   the mask update of one request is seen by the very next request.
//   reset clears the used mask (all slots free) and both valid flags; key
//   RAM contents are undefined until a slot is registered.
//   when out_ready is low the response holds, the input register holds,
//   and in_ready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module key_slot_allocator #(
    parameter int NUM_SLOTS = 63
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ksa_pkg::ksa_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ksa_pkg::ksa_out_t out_data
);
    import ksa_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(NUM_SLOTS);

    logic                 s1_valid_reg;
    ksa_in_t              s1_data_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_get_hit_reg;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;

    logic                 advance;
    free_slot_t           free_slot;
    logic [AW-1:0]        req_addr;
    logic                 in_range;
    logic                 slot_used;
    logic [NUM_SLOTS-1:0] grant_onehot;
    logic [NUM_SLOTS-1:0] req_onehot;
    logic [1:0]           status_next;
    logic [SLOT_W-1:0]    slot_next;
    logic                 get_hit_next;
    logic                 wr_en;
    logic [KEY_W-1:0]     rd_key;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    ksa_free_enc #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_free_enc (
        .used_mask(mask_reg),
        .result   (free_slot)
    );

    assign req_addr     = s1_data_reg.slot_index[AW-1:0];
    assign in_range     = {1'b0, s1_data_reg.slot_index} < SLOT_LIMIT;
    assign slot_used    = in_range && mask_reg[req_addr];
    assign grant_onehot = NUM_SLOTS'(1) << free_slot.slot;
    assign req_onehot   = NUM_SLOTS'(1) << s1_data_reg.slot_index;

    always_comb
    begin
        status_next  = ST_MISS;
        slot_next    = '0;
        get_hit_next = 1'b0;
        mask_next    = mask_reg;
        wr_en        = 1'b0;
        unique case (s1_data_reg.func)
            FUNC_REGISTER:
            begin
                if (free_slot.found)
                begin
                    status_next = ST_OK;
                    slot_next   = free_slot.slot;
                    mask_next   = mask_reg | grant_onehot;
                    wr_en       = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            FUNC_UNREGISTER:
            begin
                if (slot_used)
                begin
                    status_next = ST_OK;
                    mask_next   = mask_reg & ~req_onehot;
                end
            end
            FUNC_GET:
            begin
                if (slot_used)
                begin
                    status_next  = ST_OK;
                    get_hit_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    ksa_ram #(
        .WIDTH(KEY_W),
        .DEPTH(NUM_SLOTS),
        .AW   (AW)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (advance && wr_en),
        .wr_addr(free_slot.slot[AW-1:0]),
        .wr_data({s1_data_reg.key_word_3, s1_data_reg.key_word_2,
                  s1_data_reg.key_word_1, s1_data_reg.key_word_0}),
        .rd_en  (advance),
        .rd_addr(req_addr),
        .rd_data(rd_key)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mask_reg      <= mask_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_status_reg  <= status_next;
            out_slot_reg    <= slot_next;
            out_get_hit_reg <= get_hit_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.status       = out_status_reg;
    assign out_data.granted_slot = out_slot_reg;
    assign out_data.out_word_0   = out_get_hit_reg ? rd_key[0*WORD_W +: WORD_W] : '0;
    assign out_data.out_word_1   = out_get_hit_reg ? rd_key[1*WORD_W +: WORD_W] : '0;
    assign out_data.out_word_2   = out_get_hit_reg ? rd_key[2*WORD_W +: WORD_W] : '0;
    assign out_data.out_word_3   = out_get_hit_reg ? rd_key[3*WORD_W +: WORD_W] : '0;

`ifndef ASSERT_OFF
    // a granted slot is reported only with a successful status
    a_slot_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |-> (out_slot_reg == '0))
        else $error("granted slot set on a failed transaction");

    // full is reported only when every slot is in use
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_data_reg.func == FUNC_REGISTER) && !free_slot.found
        |-> (&mask_reg))
        else $error("full reported with a free slot");

    // a successful register marks the granted slot as used
    a_grant_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_data_reg.func == FUNC_REGISTER) && free_slot.found
        |=> ((mask_reg & $past(grant_onehot)) != '0))
        else $error("granted slot not marked used");
`endif

endmodule
